### design/tflp_pkg.sv
// Package for the thermal fan level policy block.
// Holds widths, codes, the configuration set and the queue entry/result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tflp_pkg;

  localparam int TEMP_W   = 19;
  localparam int SUM_W    = TEMP_W + 1;
  localparam int THR_W    = 18;
  localparam int MARGIN_W = 16;
  localparam int DUTY_W   = 7;
  localparam int MASK_W   = 6;
  localparam int CFG_W    = 18;

  localparam int NUM_FANS = 6;
  localparam logic [MASK_W-1:0] FAN_MASK = MASK_W'((64'd1 << NUM_FANS) - 64'd1);

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [THR_W-1:0]    RST_THRESH_MID  = THR_W'(41000);
  localparam logic [THR_W-1:0]    RST_THRESH_FULL = THR_W'(46000);
  localparam logic [THR_W-1:0]    RST_THRESH_HIGH = THR_W'(61000);
  localparam logic [THR_W-1:0]    RST_THRESH_CRIT = THR_W'(66000);
  localparam logic [MARGIN_W-1:0] RST_CLR_MARGIN  = MARGIN_W'(5000);
  localparam logic [DUTY_W-1:0]   RST_DUTY_LOW    = DUTY_W'(50);
  localparam logic [DUTY_W-1:0]   RST_DUTY_MID    = DUTY_W'(75);
  localparam logic [DUTY_W-1:0]   RST_DUTY_FULL   = DUTY_W'(100);

  typedef enum logic [2:0] {
    LVL_DEFAULT = 3'd0,
    LVL_MID     = 3'd1,
    LVL_FULL    = 3'd2,
    LVL_HIGH    = 3'd3,
    LVL_CRIT    = 3'd4
  } level_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_SENSOR_FAIL = 2'd1,
    ST_DUTY_FAIL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_THRESH_MID  = 3'd0,
    CFG_THRESH_FULL = 3'd1,
    CFG_THRESH_HIGH = 3'd2,
    CFG_THRESH_CRIT = 3'd3,
    CFG_CLR_MARGIN  = 3'd4,
    CFG_DUTY_LOW    = 3'd5,
    CFG_DUTY_MID    = 3'd6,
    CFG_DUTY_FULL   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]    thresh_mid;
    logic [THR_W-1:0]    thresh_full;
    logic [THR_W-1:0]    thresh_high;
    logic [THR_W-1:0]    thresh_crit;
    logic [MARGIN_W-1:0] clear_margin;
    logic [DUTY_W-1:0]   duty_low;
    logic [DUTY_W-1:0]   duty_mid;
    logic [DUTY_W-1:0]   duty_full;
  } cfg_t;

  // Classified poll, as it waits between the front and the back.
  typedef struct packed {
    status_t             status;
    level_t              temp_level;
    logic                fault;
    logic                below_clear;
    logic                duty_write;
    logic [DUTY_W-1:0]   duty_value;
    logic                wdt_enable;
    logic                wdt_kick;
  } cls_t;

  typedef struct packed {
    logic                duty_write;
    logic [DUTY_W-1:0]   duty_value;
    level_t              level;
    logic                alarm_active;
    logic                alarm_raised;
    logic                alarm_cleared;
    logic                shutdown_request;
    logic                wdt_enable;
    logic                wdt_kick;
    status_t             status;
  } res_t;

endpackage
`default_nettype wire

### design/tflp_in_if.sv
// Poll channel: valid/ready handshake with the sensor, duty, fan and watchdog readings.
// Depends on tflp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface tflp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tflp_pkg::TEMP_W-1:0]  temp_a;
  logic signed [tflp_pkg::TEMP_W-1:0]  temp_b;
  logic                                temps_ok;
  logic                                duty_read_ok;
  logic [tflp_pkg::DUTY_W-1:0]         current_duty;
  logic [tflp_pkg::MASK_W-1:0]         fan_fault_mask;
  logic                                wdt_read_ok;
  logic                                wdt_disabled;

  modport source (
    output valid, temp_a, temp_b, temps_ok, duty_read_ok, current_duty,
           fan_fault_mask, wdt_read_ok, wdt_disabled,
    input  ready
  );
  modport sink (
    input  valid, temp_a, temp_b, temps_ok, duty_read_ok, current_duty,
           fan_fault_mask, wdt_read_ok, wdt_disabled,
    output ready
  );
endinterface
`default_nettype wire

### design/tflp_out_if.sv
// Result channel: valid/ready handshake with the per-poll policy decision.
// Depends on tflp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface tflp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         duty_write;
  logic [tflp_pkg::DUTY_W-1:0]  duty_value;
  logic [2:0]                   level;
  logic                         alarm_active;
  logic                         alarm_raised;
  logic                         alarm_cleared;
  logic                         shutdown_request;
  logic                         wdt_enable;
  logic                         wdt_kick;
  logic [1:0]                   status;

  modport source (
    output valid, duty_write, duty_value, level, alarm_active, alarm_raised,
           alarm_cleared, shutdown_request, wdt_enable, wdt_kick, status,
    input  ready
  );
  modport sink (
    input  valid, duty_write, duty_value, level, alarm_active, alarm_raised,
           alarm_cleared, shutdown_request, wdt_enable, wdt_kick, status,
    output ready
  );
endinterface
`default_nettype wire

### design/tflp_front.sv
// Front classifier: averages the readings, sorts into a temperature level, settles duty.
// Depends on tflp_pkg. Carries no state; the result is written into the queue.
`timescale 1ns / 1ps
`default_nettype none
module tflp_front (
  input  tflp_pkg::cfg_t                     cfg,
  input  logic signed [tflp_pkg::TEMP_W-1:0] temp_a,
  input  logic signed [tflp_pkg::TEMP_W-1:0] temp_b,
  input  logic                               temps_ok,
  input  logic                               duty_read_ok,
  input  logic [tflp_pkg::DUTY_W-1:0]        current_duty,
  input  logic [tflp_pkg::MASK_W-1:0]        fan_fault_mask,
  input  logic                               wdt_read_ok,
  input  logic                               wdt_disabled,
  output tflp_pkg::cls_t                     cls
);

  logic signed [tflp_pkg::SUM_W-1:0] sum;
  logic signed [tflp_pkg::SUM_W-1:0] avg;
  logic signed [tflp_pkg::SUM_W-1:0] thr_mid_s, thr_full_s, thr_high_s, thr_crit_s;
  logic signed [tflp_pkg::SUM_W-1:0] clr_thr;
  logic                              gt_mid, gt_full, gt_high, gt_crit;
  tflp_pkg::level_t                  temp_level;
  logic [tflp_pkg::DUTY_W-1:0]       lvl_duty;
  logic                              fault;

  localparam int EXT_T = tflp_pkg::SUM_W - tflp_pkg::THR_W;
  localparam int EXT_M = tflp_pkg::SUM_W - tflp_pkg::MARGIN_W;

  // Truncate toward zero: add one to negative sums before the halving shift.
  assign sum = {temp_a[tflp_pkg::TEMP_W-1], temp_a} + {temp_b[tflp_pkg::TEMP_W-1], temp_b};
  assign avg = signed'(sum + {{(tflp_pkg::SUM_W-1){1'b0}}, sum[tflp_pkg::SUM_W-1]}) >>> 1;

  assign thr_mid_s  = signed'({{EXT_T{1'b0}}, cfg.thresh_mid});
  assign thr_full_s = signed'({{EXT_T{1'b0}}, cfg.thresh_full});
  assign thr_high_s = signed'({{EXT_T{1'b0}}, cfg.thresh_high});
  assign thr_crit_s = signed'({{EXT_T{1'b0}}, cfg.thresh_crit});
  assign clr_thr    = thr_high_s - signed'({{EXT_M{1'b0}}, cfg.clear_margin});

  assign gt_mid  = avg > thr_mid_s;
  assign gt_full = avg > thr_full_s;
  assign gt_high = avg > thr_high_s;
  assign gt_crit = avg > thr_crit_s;

  // Highest matching band wins, which also covers unordered thresholds.
  always_comb begin
    if (gt_crit) begin
      temp_level = tflp_pkg::LVL_CRIT;
    end else if (gt_high) begin
      temp_level = tflp_pkg::LVL_HIGH;
    end else if (gt_full) begin
      temp_level = tflp_pkg::LVL_FULL;
    end else if (gt_mid) begin
      temp_level = tflp_pkg::LVL_MID;
    end else begin
      temp_level = tflp_pkg::LVL_DEFAULT;
    end
  end

  always_comb begin
    unique case (temp_level)
      tflp_pkg::LVL_DEFAULT: lvl_duty = cfg.duty_low;
      tflp_pkg::LVL_MID:     lvl_duty = cfg.duty_mid;
      default:               lvl_duty = cfg.duty_full;
    endcase
  end

  assign fault = |(fan_fault_mask & tflp_pkg::FAN_MASK);

  always_comb begin
    cls             = '0;
    cls.temp_level  = temp_level;
    cls.fault       = fault;
    cls.below_clear = avg < clr_thr;
    cls.wdt_kick    = wdt_read_ok;
    cls.wdt_enable  = wdt_read_ok & wdt_disabled;
    if (!temps_ok) begin
      cls.status     = tflp_pkg::ST_SENSOR_FAIL;
      cls.duty_write = 1'b1;
      cls.duty_value = cfg.duty_mid;
    end else if (!duty_read_ok) begin
      cls.status     = tflp_pkg::ST_DUTY_FAIL;
    end else begin
      cls.status = tflp_pkg::ST_OK;
      if (fault) begin
        cls.duty_write = 1'b1;
        cls.duty_value = cfg.duty_full;
      end else if (current_duty != lvl_duty) begin
        cls.duty_write = 1'b1;
        cls.duty_value = lvl_duty;
      end
    end
  end

endmodule
`default_nettype wire

### design/tflp_queue.sv
// Short register queue between the front classifier and the back state stage.
// Depends on tflp_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none
module tflp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tflp_pkg::cls_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tflp_pkg::cls_t pop_data
);

  tflp_pkg::cls_t                mem_r [tflp_pkg::Q_DEPTH];
  logic [tflp_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tflp_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tflp_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  localparam logic [tflp_pkg::QPTR_W-1:0] LAST = tflp_pkg::QPTR_W'(tflp_pkg::Q_DEPTH - 1);
  localparam logic [tflp_pkg::QCNT_W-1:0] FULL_CNT = tflp_pkg::QCNT_W'(tflp_pkg::Q_DEPTH);

  assign full      = cnt_r == FULL_CNT;
  assign not_empty = cnt_r != '0;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### design/tflp_back.sv
// Back stage: applies fan level and alarm state to classified polls, holds the result beat.
// Depends on tflp_pkg for the entry and result types.
`timescale 1ns / 1ps
`default_nettype none
module tflp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  tflp_pkg::cls_t q_data,
  output logic           q_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output tflp_pkg::res_t res
);

  tflp_pkg::level_t fan_level_r, fan_level_nxt;
  logic             alarm_r, alarm_nxt;
  logic             valid_r, valid_nxt;
  tflp_pkg::res_t   res_r, res_nxt;

  tflp_pkg::level_t new_level;
  logic             changed, raised, cleared, shutdown, alarm_mid;

  assign q_pop     = q_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    new_level = q_data.temp_level;
    if (q_data.fault &&
        (fan_level_r < tflp_pkg::LVL_FULL || q_data.temp_level < tflp_pkg::LVL_FULL)) begin
      new_level = tflp_pkg::LVL_FULL;
    end
    changed   = new_level != fan_level_r;
    raised    = changed && new_level == tflp_pkg::LVL_HIGH &&
                fan_level_r <= tflp_pkg::LVL_FULL && !alarm_r;
    shutdown  = changed && new_level == tflp_pkg::LVL_CRIT;
    alarm_mid = alarm_r | raised;
    cleared   = alarm_mid && new_level < tflp_pkg::LVL_HIGH && q_data.below_clear;

    fan_level_nxt = fan_level_r;
    alarm_nxt     = alarm_r;
    res_nxt       = '0;
    res_nxt.duty_write = q_data.duty_write;
    res_nxt.duty_value = q_data.duty_value;
    res_nxt.wdt_enable = q_data.wdt_enable;
    res_nxt.wdt_kick   = q_data.wdt_kick;
    res_nxt.status     = q_data.status;
    if (q_data.status == tflp_pkg::ST_OK) begin
      fan_level_nxt = new_level;
      alarm_nxt     = alarm_mid & ~cleared;
      res_nxt.alarm_raised     = raised;
      res_nxt.alarm_cleared    = cleared;
      res_nxt.shutdown_request = shutdown;
    end
    res_nxt.level        = fan_level_nxt;
    res_nxt.alarm_active = alarm_nxt;

    valid_nxt = q_pop ? 1'b1 : (res_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_level_r <= tflp_pkg::LVL_DEFAULT;
      alarm_r     <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (q_pop) begin
        fan_level_r <= fan_level_nxt;
        alarm_r     <= alarm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

### design/thermal_fan_level_policy_top.sv
// Top level of the thermal fan level policy block.
// Depends on tflp_pkg, tflp_in_if, tflp_out_if, tflp_front, tflp_queue and tflp_back.
`timescale 1ns / 1ps
`default_nettype none
// One poll beat in gives one result beat out. The block sustains one beat per
// cycle while the output side is not stalled: the front classifier (average,
// threshold compares, duty choice) sits combinationally in front of a two-entry
// queue, and the back stage applies the fan level and alarm state to each beat
// and loads the output register, from which the result is presented. The input
// side keeps accepting while a finished result waits, until the queue is full.
// Configuration registers are written through cfg_we/cfg_idx/cfg_wdata and must
// be changed only when no poll is in flight; write data is truncated to each
// register's width. Reset is synchronous and active low and loads the default
// thresholds and duties.
module thermal_fan_level_policy_top (
  input  logic                        clk,
  input  logic                        rst_n,
  tflp_in_if.sink                     in_ch,
  tflp_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_idx,
  input  logic [tflp_pkg::CFG_W-1:0]  cfg_wdata
);

  tflp_pkg::cfg_t cfg_r;
  tflp_pkg::cls_t front_cls;
  tflp_pkg::cls_t q_data;
  tflp_pkg::res_t res;
  logic           q_full, q_valid, q_pop, push;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thresh_mid   <= tflp_pkg::RST_THRESH_MID;
      cfg_r.thresh_full  <= tflp_pkg::RST_THRESH_FULL;
      cfg_r.thresh_high  <= tflp_pkg::RST_THRESH_HIGH;
      cfg_r.thresh_crit  <= tflp_pkg::RST_THRESH_CRIT;
      cfg_r.clear_margin <= tflp_pkg::RST_CLR_MARGIN;
      cfg_r.duty_low     <= tflp_pkg::RST_DUTY_LOW;
      cfg_r.duty_mid     <= tflp_pkg::RST_DUTY_MID;
      cfg_r.duty_full    <= tflp_pkg::RST_DUTY_FULL;
    end else if (cfg_we) begin
      unique case (tflp_pkg::cfg_idx_t'(cfg_idx))
        tflp_pkg::CFG_THRESH_MID:  cfg_r.thresh_mid   <= cfg_wdata[tflp_pkg::THR_W-1:0];
        tflp_pkg::CFG_THRESH_FULL: cfg_r.thresh_full  <= cfg_wdata[tflp_pkg::THR_W-1:0];
        tflp_pkg::CFG_THRESH_HIGH: cfg_r.thresh_high  <= cfg_wdata[tflp_pkg::THR_W-1:0];
        tflp_pkg::CFG_THRESH_CRIT: cfg_r.thresh_crit  <= cfg_wdata[tflp_pkg::THR_W-1:0];
        tflp_pkg::CFG_CLR_MARGIN:  cfg_r.clear_margin <= cfg_wdata[tflp_pkg::MARGIN_W-1:0];
        tflp_pkg::CFG_DUTY_LOW:    cfg_r.duty_low     <= cfg_wdata[tflp_pkg::DUTY_W-1:0];
        tflp_pkg::CFG_DUTY_MID:    cfg_r.duty_mid     <= cfg_wdata[tflp_pkg::DUTY_W-1:0];
        tflp_pkg::CFG_DUTY_FULL:   cfg_r.duty_full    <= cfg_wdata[tflp_pkg::DUTY_W-1:0];
      endcase
    end
  end

  // Front: classify the poll beat; it carries no state, so it never stalls on its own.
  tflp_front u_front (
    .cfg            (cfg_r),
    .temp_a         (in_ch.temp_a),
    .temp_b         (in_ch.temp_b),
    .temps_ok       (in_ch.temps_ok),
    .duty_read_ok   (in_ch.duty_read_ok),
    .current_duty   (in_ch.current_duty),
    .fan_fault_mask (in_ch.fan_fault_mask),
    .wdt_read_ok    (in_ch.wdt_read_ok),
    .wdt_disabled   (in_ch.wdt_disabled),
    .cls            (front_cls)
  );

  // Accept a beat whenever the queue has room.
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  tflp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // Back: advance state and hold the result beat until the sink takes it.
  tflp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.duty_write       = res.duty_write;
  assign out_ch.duty_value       = res.duty_value;
  assign out_ch.level            = res.level;
  assign out_ch.alarm_active     = res.alarm_active;
  assign out_ch.alarm_raised     = res.alarm_raised;
  assign out_ch.alarm_cleared    = res.alarm_cleared;
  assign out_ch.shutdown_request = res.shutdown_request;
  assign out_ch.wdt_enable       = res.wdt_enable;
  assign out_ch.wdt_kick         = res.wdt_kick;
  assign out_ch.status           = res.status;

  // A shutdown request only comes with the critical level.
  a_shutdown_crit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.shutdown_request |-> out_ch.level == tflp_pkg::LVL_CRIT)
    else $error("shutdown request without critical level");

  // A raised alarm leaves the alarm active at the high level, never cleared in the same beat.
  a_raise_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.alarm_raised |->
      out_ch.alarm_active && out_ch.level == tflp_pkg::LVL_HIGH && !out_ch.alarm_cleared)
    else $error("alarm raise inconsistent with level or alarm flag");

  // Failed polls keep the state, so they report no events.
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != tflp_pkg::ST_OK |->
      !out_ch.alarm_raised && !out_ch.alarm_cleared && !out_ch.shutdown_request)
    else $error("event reported on a failed poll");

  // A cleared alarm reads inactive in the same beat.
  a_clear_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.alarm_cleared |-> !out_ch.alarm_active)
    else $error("alarm cleared but still active");

endmodule
`default_nettype wire

### tb/sv/thermal_fan_level_policy_top_tb.sv
// Testbench for thermal_fan_level_policy_top: directed polls, then random polls under
// several threshold/duty settings, with every result beat checked against a local predictor or a pinned result.
// Depends on tflp_pkg, tflp_in_if, tflp_out_if and the block's RTL.
`timescale 1ns / 1ps
module thermal_fan_level_policy_top_tb;
  import tflp_pkg::*;

  localparam int TEMP_MIN = -131072;
  localparam int TEMP_MAX = 262143;
  localparam int THR_MAX  = (1 << THR_W) - 1;

  // One poll as the sender drives it.
  typedef struct {
    logic signed [TEMP_W-1:0] temp_a;
    logic signed [TEMP_W-1:0] temp_b;
    logic                     temps_ok;
    logic                     duty_read_ok;
    logic [DUTY_W-1:0]        current_duty;
    logic [MASK_W-1:0]        fan_fault_mask;
    logic                     wdt_read_ok;
    logic                     wdt_disabled;
  } poll_t;

  // Stimulus row: a poll and, where it can be read off directly, a pinned result.
  typedef struct {
    poll_t p;
    bit    pinned;
    res_t  want;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [2:0]       cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  tflp_in_if  poll_bus ();
  tflp_out_if res_bus ();

  thermal_fan_level_policy_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (poll_bus.sink),
    .out_ch    (res_bus.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the configuration and the policy state.
  int     thr_mid, thr_full, thr_high, thr_crit, clr_margin;
  int     duty_lo, duty_md, duty_fl;
  level_t fan_lvl;
  bit     alarm_on;

  res_t   pending_res[$];   // expected result beats, oldest first
  int     err_cnt;
  bit     tx_steady;        // sender runs without gaps while set
  bit     rx_steady;        // receiver never stalls while set

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("thermal_fan_level_policy_top_tb: done, errors");
    $finish;
  end

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < 40)
      $display("%0t MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Work out one poll's result and advance the predictor state.
  function automatic res_t fan_policy(poll_t p);
    res_t   r;
    int     avg;
    int     lvl_duty;
    level_t old_lvl;
    level_t lvl;
    r = '0;
    r.wdt_kick   = p.wdt_read_ok;
    r.wdt_enable = p.wdt_read_ok & p.wdt_disabled;
    r.status     = ST_OK;
    if (!p.temps_ok) begin
      r.duty_write = 1'b1;
      r.duty_value = DUTY_W'(duty_md);
      r.status     = ST_SENSOR_FAIL;
    end else if (!p.duty_read_ok) begin
      r.status = ST_DUTY_FAIL;
    end else begin
      // Signed sum, division truncates toward zero.
      avg     = (int'(p.temp_a) + int'(p.temp_b)) / 2;
      old_lvl = fan_lvl;
      lvl     = LVL_DEFAULT;
      // Bands are tested in order; the last match wins.
      if (avg > thr_mid  && avg <= thr_full) lvl = LVL_MID;
      if (avg > thr_full && avg <= thr_high) lvl = LVL_FULL;
      if (avg > thr_high && avg <= thr_crit) lvl = LVL_HIGH;
      if (avg > thr_crit)                    lvl = LVL_CRIT;
      case (lvl)
        LVL_DEFAULT: lvl_duty = duty_lo;
        LVL_MID:     lvl_duty = duty_md;
        default:     lvl_duty = duty_fl;
      endcase
      if (int'(p.current_duty) != lvl_duty) begin
        r.duty_write = 1'b1;
        r.duty_value = DUTY_W'(lvl_duty);
      end
      if ((p.fan_fault_mask & FAN_MASK) != '0) begin
        r.duty_write = 1'b1;
        r.duty_value = DUTY_W'(duty_fl);
        if (old_lvl < LVL_FULL || lvl < LVL_FULL) lvl = LVL_FULL;
      end
      if (lvl != old_lvl) begin
        fan_lvl = lvl;
        if (lvl == LVL_HIGH && old_lvl <= LVL_FULL && !alarm_on) begin
          alarm_on       = 1'b1;
          r.alarm_raised = 1'b1;
        end
        if (lvl == LVL_CRIT && old_lvl <= LVL_HIGH) r.shutdown_request = 1'b1;
      end
      // Clear point may be negative when the margin exceeds the high threshold.
      if (alarm_on && lvl < LVL_HIGH && avg < thr_high - clr_margin) begin
        alarm_on        = 1'b0;
        r.alarm_cleared = 1'b1;
      end
    end
    r.level        = fan_lvl;
    r.alarm_active = alarm_on;
    return r;
  endfunction

  function automatic row_t dr(int ta, int tb, bit tok, bit dok, int duty, int mask,
                              bit wok, bit wdis);
    row_t r;
    r.p.temp_a         = TEMP_W'(ta);
    r.p.temp_b         = TEMP_W'(tb);
    r.p.temps_ok       = tok;
    r.p.duty_read_ok   = dok;
    r.p.current_duty   = DUTY_W'(duty);
    r.p.fan_fault_mask = MASK_W'(mask);
    r.p.wdt_read_ok    = wok;
    r.p.wdt_disabled   = wdis;
    r.pinned           = 1'b0;
    r.want             = '0;
    return r;
  endfunction

  function automatic row_t pin(row_t r, res_t w);
    r.pinned = 1'b1;
    r.want   = w;
    return r;
  endfunction

  function automatic int clamp_temp(int t);
    if (t < TEMP_MIN) return TEMP_MIN;
    if (t > TEMP_MAX) return TEMP_MAX;
    return t;
  endfunction

  // Gap length: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Random poll, biased so the average lands near the thresholds and the clear point,
  // which is where level changes, alarms and shutdowns happen.
  function automatic row_t rand_poll();
    int sel, avg, d, ta, tb, duty, mask;
    int pts[5];
    pts = '{thr_mid, thr_full, thr_high, thr_crit, thr_high - clr_margin};
    sel = $urandom_range(0, 9);
    if (sel <= 6) begin
      avg = pts[$urandom_range(0, 4)];
      if (sel == 6) avg += int'($urandom_range(0, 4000)) - 2000;
      else          avg += int'($urandom_range(0, 20)) - 10;
      d  = $urandom_range(0, 3000);
      ta = clamp_temp(avg + d);
      tb = clamp_temp(avg - d + int'($urandom_range(0, 1)));
    end else if (sel == 7) begin
      ta = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
      tb = int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    end else if (sel == 8) begin
      ta = int'($urandom_range(0, 20)) - 10;
      tb = int'($urandom_range(0, 20)) - 10;
    end else begin
      pts = '{TEMP_MIN, TEMP_MAX, 0, -1, 1};
      ta  = pts[$urandom_range(0, 4)];
      tb  = pts[$urandom_range(0, 4)];
    end
    // Half the time report a duty that already matches one of the levels.
    if ($urandom_range(0, 1) == 0) begin
      pts  = '{duty_lo, duty_md, duty_fl, duty_lo, duty_fl};
      duty = pts[$urandom_range(0, 4)];
    end else begin
      duty = $urandom_range(0, 100);
    end
    mask = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63) : 0;
    return dr(ta, tb, $urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0, duty, mask,
              $urandom_range(0, 1), $urandom_range(0, 1));
  endfunction

  // Drive one poll beat from the falling edge, hold it until accepted, then maybe idle.
  task automatic send_poll(row_t r);
    int   gap;
    res_t pred;
    @(negedge clk);
    poll_bus.valid          <= 1'b1;
    poll_bus.temp_a         <= r.p.temp_a;
    poll_bus.temp_b         <= r.p.temp_b;
    poll_bus.temps_ok       <= r.p.temps_ok;
    poll_bus.duty_read_ok   <= r.p.duty_read_ok;
    poll_bus.current_duty   <= r.p.current_duty;
    poll_bus.fan_fault_mask <= r.p.fan_fault_mask;
    poll_bus.wdt_read_ok    <= r.p.wdt_read_ok;
    poll_bus.wdt_disabled   <= r.p.wdt_disabled;
    do @(posedge clk); while (poll_bus.ready !== 1'b1);
    // Always run the predictor so its state follows the block, even on pinned rows.
    pred = fan_policy(r.p);
    pending_res.push_back(r.pinned ? r.want : pred);
    gap = (!tx_steady && $urandom_range(0, 99) < 45) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      poll_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, hold until every expected beat is back, then let the pipe settle.
  task automatic drain();
    @(negedge clk);
    poll_bus.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CFG_W'(val);
    // The block keeps only the register's own width.
    case (idx)
      CFG_THRESH_MID:  thr_mid    = val & THR_MAX;
      CFG_THRESH_FULL: thr_full   = val & THR_MAX;
      CFG_THRESH_HIGH: thr_high   = val & THR_MAX;
      CFG_THRESH_CRIT: thr_crit   = val & THR_MAX;
      CFG_CLR_MARGIN:  clr_margin = val & ((1 << MARGIN_W) - 1);
      CFG_DUTY_LOW:    duty_lo    = val & ((1 << DUTY_W) - 1);
      CFG_DUTY_MID:    duty_md    = val & ((1 << DUTY_W) - 1);
      default:         duty_fl    = val & ((1 << DUTY_W) - 1);
    endcase
  endtask

  // Write all eight registers; junk in the upper bits of the margin and duty values checks the truncation.
  task automatic apply_cfg(int mid, int full, int high, int crit, int margin,
                           int dlow, int dmid, int dfull);
    set_reg(CFG_THRESH_MID,  mid);
    set_reg(CFG_THRESH_FULL, full);
    set_reg(CFG_THRESH_HIGH, high);
    set_reg(CFG_THRESH_CRIT, crit);
    set_reg(CFG_CLR_MARGIN,  margin | (int'($urandom_range(0, 3)) << MARGIN_W));
    set_reg(CFG_DUTY_LOW,    dlow   | (int'($urandom_range(0, 2047)) << DUTY_W));
    set_reg(CFG_DUTY_MID,    dmid   | (int'($urandom_range(0, 2047)) << DUTY_W));
    set_reg(CFG_DUTY_FULL,   dfull  | (int'($urandom_range(0, 2047)) << DUTY_W));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) begin
      // Switch between gappy and back-to-back stretches on both sides.
      if (k % 32 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_poll(rand_poll());
    end
  endtask

  // Result side: random stalls of random length, driven at the falling edge.
  initial begin : rx_ready
    int stall;
    stall         = 0;
    res_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 25) stall = idle_len();
      end
    end
  end

  // Check every accepted result beat against the oldest expectation, field by field.
  always @(posedge clk) begin : rx_check
    res_t got;
    res_t want;
    if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got.duty_write       = res_bus.duty_write;
      got.duty_value       = res_bus.duty_value;
      got.level            = level_t'(res_bus.level);
      got.alarm_active     = res_bus.alarm_active;
      got.alarm_raised     = res_bus.alarm_raised;
      got.alarm_cleared    = res_bus.alarm_cleared;
      got.shutdown_request = res_bus.shutdown_request;
      got.wdt_enable       = res_bus.wdt_enable;
      got.wdt_kick         = res_bus.wdt_kick;
      got.status           = status_t'(res_bus.status);
      if (pending_res.size() == 0) begin
        note_mismatch("result beat with no poll waiting", 32'(got), 0);
      end else begin
        want = pending_res.pop_front();
        if (got.duty_write !== want.duty_write)
          note_mismatch("duty_write", got.duty_write, want.duty_write);
        if (got.duty_value !== want.duty_value)
          note_mismatch("duty_value", got.duty_value, want.duty_value);
        if (got.level !== want.level)
          note_mismatch("level", got.level, want.level);
        if (got.alarm_active !== want.alarm_active)
          note_mismatch("alarm_active", got.alarm_active, want.alarm_active);
        if (got.alarm_raised !== want.alarm_raised)
          note_mismatch("alarm_raised", got.alarm_raised, want.alarm_raised);
        if (got.alarm_cleared !== want.alarm_cleared)
          note_mismatch("alarm_cleared", got.alarm_cleared, want.alarm_cleared);
        if (got.shutdown_request !== want.shutdown_request)
          note_mismatch("shutdown_request", got.shutdown_request, want.shutdown_request);
        if (got.wdt_enable !== want.wdt_enable)
          note_mismatch("wdt_enable", got.wdt_enable, want.wdt_enable);
        if (got.wdt_kick !== want.wdt_kick)
          note_mismatch("wdt_kick", got.wdt_kick, want.wdt_kick);
        if (got.status !== want.status)
          note_mismatch("status", got.status, want.status);
      end
    end
  end

  initial begin : main_seq
    row_t poll_rows[$];
    int   a, b, c, guard;

    // Known values on every input from time zero; reset held low.
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = CFG_THRESH_MID;
    cfg_wdata               = '0;
    poll_bus.valid          = 1'b0;
    poll_bus.temp_a         = '0;
    poll_bus.temp_b         = '0;
    poll_bus.temps_ok       = 1'b0;
    poll_bus.duty_read_ok   = 1'b0;
    poll_bus.current_duty   = '0;
    poll_bus.fan_fault_mask = '0;
    poll_bus.wdt_read_ok    = 1'b0;
    poll_bus.wdt_disabled   = 1'b0;
    err_cnt                 = 0;
    tx_steady               = 1'b0;
    rx_steady               = 1'b0;

    // Predictor starts from the reset values.
    thr_mid    = RST_THRESH_MID;
    thr_full   = RST_THRESH_FULL;
    thr_high   = RST_THRESH_HIGH;
    thr_crit   = RST_THRESH_CRIT;
    clr_margin = RST_CLR_MARGIN;
    duty_lo    = RST_DUTY_LOW;
    duty_md    = RST_DUTY_MID;
    duty_fl    = RST_DUTY_FULL;
    fan_lvl    = LVL_DEFAULT;
    alarm_on   = 1'b0;

    // Directed rows under reset configuration. Columns: temp_a, temp_b, temps_ok,
    // duty_read_ok, current_duty, fan mask, wdt_read_ok, wdt_disabled.
    // Sensor read failure right after reset: mid duty, state kept, enable and kick.
    poll_rows.push_back(pin(dr(0, 0, 0, 1, 50, 0, 1, 1),
      '{duty_write: 1'b1, duty_value: 7'd75, level: LVL_DEFAULT, alarm_active: 1'b0,
        alarm_raised: 1'b0, alarm_cleared: 1'b0, shutdown_request: 1'b0,
        wdt_enable: 1'b1, wdt_kick: 1'b1, status: ST_SENSOR_FAIL}));
    // Duty read failure: nothing written, kick only.
    poll_rows.push_back(pin(dr(50000, 50000, 1, 0, 50, 0, 1, 0),
      '{duty_write: 1'b0, duty_value: 7'd0, level: LVL_DEFAULT, alarm_active: 1'b0,
        alarm_raised: 1'b0, alarm_cleared: 1'b0, shutdown_request: 1'b0,
        wdt_enable: 1'b0, wdt_kick: 1'b1, status: ST_DUTY_FAIL}));
    // Default level with matching duty: no write, duty field zero, watchdog unread.
    poll_rows.push_back(pin(dr(20000, 20000, 1, 1, 50, 0, 0, 1),
      '{duty_write: 1'b0, duty_value: 7'd0, level: LVL_DEFAULT, alarm_active: 1'b0,
        alarm_raised: 1'b0, alarm_cleared: 1'b0, shutdown_request: 1'b0,
        wdt_enable: 1'b0, wdt_kick: 1'b0, status: ST_OK}));
    poll_rows.push_back(dr(43000, 43000, 1, 1, 50, 0, 0, 0));         // up to mid
    poll_rows.push_back(dr(41000, 41001, 1, 1, 75, 0, 1, 1));         // average on mid bound
    poll_rows.push_back(dr(41001, 41002, 1, 1, 50, 0, 1, 0));         // just above mid
    poll_rows.push_back(dr(50000, 50000, 1, 1, 75, 0, 0, 1));         // full
    poll_rows.push_back(dr(62000, 62000, 1, 1, 100, 0, 1, 1));        // high, alarm raised
    poll_rows.push_back(dr(70000, 70000, 1, 1, 100, 0, 1, 0));        // critical, shutdown
    poll_rows.push_back(dr(TEMP_MAX, TEMP_MAX, 1, 1, 100, 0, 0, 0));  // top of range
    poll_rows.push_back(dr(62000, 62000, 1, 1, 100, 0, 1, 1));        // critical back to high
    poll_rows.push_back(dr(TEMP_MIN, TEMP_MIN, 1, 1, 0, 0, 1, 1));    // bottom, alarm clears
    poll_rows.push_back(dr(1, -1, 1, 1, 127, 0, 0, 0));               // average exactly zero
    poll_rows.push_back(dr(-3, 0, 1, 1, 50, 0, 1, 0));                // negative truncation
    poll_rows.push_back(dr(20000, 20000, 1, 1, 50, 6'h20, 1, 1));     // fault from low level
    poll_rows.push_back(dr(62000, 62000, 1, 1, 100, 6'h01, 0, 1));    // fault, temp level high
    poll_rows.push_back(dr(20000, 20000, 1, 1, 50, 6'h3F, 1, 0));     // fault from high
    poll_rows.push_back(dr(TEMP_MAX, TEMP_MIN, 0, 1, 100, 6'h3F, 1, 1)); // sensor fail, kept
    poll_rows.push_back(dr(TEMP_MAX, TEMP_MIN, 1, 1, 100, 0, 1, 1));  // mixed signs -> high
    poll_rows.push_back(dr(66000, 66001, 1, 1, 100, 0, 0, 0));        // average on crit bound
    poll_rows.push_back(dr(66001, 66002, 1, 1, 100, 0, 1, 1));        // just above crit
    poll_rows.push_back(dr(TEMP_MIN, 0, 1, 0, 127, 6'h2A, 0, 1));     // duty fail, kept
    poll_rows.push_back(dr(55000, 56000, 1, 1, 100, 0, 1, 0));        // just below clear point

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (poll_rows[k]) send_poll(poll_rows[k]);
    drain();

    // Reset configuration, with one full pause part way through.
    run_random(60);
    drain();
    run_random(60);
    drain();

    // All registers at zero: any positive average is critical.
    apply_cfg(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(70);
    drain();

    // Thresholds and margin at their top, duties at 100: no band ever matches.
    apply_cfg(THR_MAX, THR_MAX, THR_MAX, THR_MAX, (1 << MARGIN_W) - 1, 100, 100, 100);
    run_random(70);
    drain();

    // Random ordered thresholds.
    a = $urandom_range(0, 60000);
    b = a + int'($urandom_range(0, 10000));
    c = b + int'($urandom_range(0, 20000));
    apply_cfg(a, b, c, c + int'($urandom_range(0, 10000)), $urandom_range(0, 20000),
              $urandom_range(0, 100), $urandom_range(0, 100), $urandom_range(0, 100));
    run_random(70);
    drain();

    // Random unordered thresholds.
    apply_cfg($urandom_range(0, 100000), $urandom_range(0, 100000),
              $urandom_range(0, 100000), $urandom_range(0, 100000),
              $urandom_range(0, 65535), $urandom_range(0, 100),
              $urandom_range(0, 100), $urandom_range(0, 100));
    run_random(70);
    drain();

    // Margin above the high threshold: the clear point goes negative.
    apply_cfg(1000, 2000, 3000, 4000, 60000, 30, 60, 90);
    run_random(70);

    // Wind down: wait for the last beats, bounded, then settle.
    @(negedge clk);
    poll_bus.valid <= 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (pending_res.size() != 0)
      note_mismatch("polls left without a result", pending_res.size(), 0);

    if (err_cnt == 0)
      $display("thermal_fan_level_policy_top_tb: done, clean");
    else
      $display("thermal_fan_level_policy_top_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
design/tflp_pkg.sv
design/tflp_in_if.sv
design/tflp_out_if.sv
design/tflp_front.sv
design/tflp_queue.sv
design/tflp_back.sv
design/thermal_fan_level_policy_top.sv
tb/sv/thermal_fan_level_policy_top_tb.sv
